// File: rtl/core/pnmn_pkg.sv
`timescale 1ns / 1ps

package pnmn_pkg;

  // Default width of the frame sample counter
  localparam int COUNT_BITS_DEF = 24;

  // image_kind codes
  localparam logic [1:0] KIND_BITMAP = 2'd0;
  localparam logic [1:0] KIND_GRAYMAP = 2'd1;
  localparam logic [1:0] KIND_PIXMAP = 2'd2;

  // register indexes (byte address 4*i)
  localparam logic [1:0] REG_IMAGE_KIND = 2'd0;
  localparam logic [1:0] REG_MAX_VALUE = 2'd1;
  localparam logic [1:0] REG_BIG_ENDIAN = 2'd2;
  localparam logic [1:0] REG_FRAME_SAMPLES = 2'd3;

  // what an output load carries
  localparam logic [1:0] EMIT_SINGLE = 2'd0;  // one 8-bit sample
  localparam logic [1:0] EMIT_FIRST = 2'd1;   // first byte of a 16-bit sample
  localparam logic [1:0] EMIT_SECOND = 2'd2;  // second byte of a 16-bit sample
  localparam logic [1:0] EMIT_PIXEL = 2'd3;   // one bitmap pixel

  typedef struct packed {
    logic [1:0]  image_kind;
    logic [15:0] max_value;
    logic        big_endian;
    logic [23:0] frame_samples;
  } cfg_t;

  typedef struct packed {
    logic       load_byte;
    logic       decide;
    logic       div_step;
    logic       emit;
    logic [1:0] emit_sel;
  } cmd_t;

  typedef struct packed {
    logic is_bitmap;
    logic wide;
    logic have_high;
    logic div_need;
    logic div_last;
    logic out_free;
    logic pixel_last;
  } sts_t;

endpackage

// File: rtl/core/pnmn_regs.sv
`timescale 1ns / 1ps

module pnmn_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output pnmn_pkg::cfg_t    cfg
);

  logic [1:0]  kind_r;
  logic [15:0] max_r;
  logic        big_r;
  logic [23:0] fs_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= pnmn_pkg::KIND_GRAYMAP;
      max_r  <= 16'd255;
      big_r  <= 1'b1;
      fs_r   <= 24'd1;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        pnmn_pkg::REG_IMAGE_KIND:    kind_r <= cfg_pwdata[1:0];
        pnmn_pkg::REG_MAX_VALUE:     max_r  <= cfg_pwdata[15:0];
        pnmn_pkg::REG_BIG_ENDIAN:    big_r  <= cfg_pwdata[0];
        pnmn_pkg::REG_FRAME_SAMPLES: fs_r   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      pnmn_pkg::REG_IMAGE_KIND:    cfg_prdata = {30'd0, kind_r};
      pnmn_pkg::REG_MAX_VALUE:     cfg_prdata = {16'd0, max_r};
      pnmn_pkg::REG_BIG_ENDIAN:    cfg_prdata = {31'd0, big_r};
      pnmn_pkg::REG_FRAME_SAMPLES: cfg_prdata = {8'd0, fs_r};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.image_kind    = kind_r;
  assign cfg.max_value     = max_r;
  assign cfg.big_endian    = big_r;
  assign cfg.frame_samples = fs_r;

endmodule

// File: rtl/core/pnmn_ctrl.sv
`timescale 1ns / 1ps

module pnmn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  pnmn_pkg::sts_t   sts,
  output pnmn_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_EMIT_A = 3'd3;
  localparam logic [2:0] S_EMIT_B = 3'd4;
  localparam logic [2:0] S_BIT    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_byte = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (sts.is_bitmap) begin
          state_nxt = S_BIT;
        end else if (sts.wide && !sts.have_high) begin
          state_nxt = S_IDLE;  // high byte held, nothing to emit
        end else if (sts.div_need) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_EMIT_A;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_EMIT_A;
      end
      S_EMIT_A: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = sts.wide ? pnmn_pkg::EMIT_FIRST : pnmn_pkg::EMIT_SINGLE;
          state_nxt = sts.wide ? S_EMIT_B : S_IDLE;
        end
      end
      S_EMIT_B: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = pnmn_pkg::EMIT_SECOND;
          state_nxt = S_IDLE;
        end
      end
      S_BIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = pnmn_pkg::EMIT_PIXEL;
          if (sts.pixel_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/pnmn_dp.sv
`timescale 1ns / 1ps

module pnmn_dp #(
  parameter int COUNT_BITS = pnmn_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pnmn_pkg::cfg_t   cfg,
  input  logic [7:0]       in_byte,
  input  pnmn_pkg::cmd_t   cmd,
  output pnmn_pkg::sts_t   sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_fend,
  output logic             out_clamp
);

  logic [7:0]            byte_r;
  logic [7:0]            held_r;
  logic                  have_r;
  logic [15:0]           acc_r;     // dividend shift / quotient / result
  logic [15:0]           rem_r;
  logic                  clampres_r;
  logic [3:0]            step_r;
  logic [2:0]            idx_r;
  logic [COUNT_BITS-1:0] cnt_r;

  logic                  ovalid_r;
  logic [7:0]            obyte_r;
  logic                  olast_r;
  logic                  ofend_r;
  logic                  oclamp_r;

  logic [15:0] max_v;
  logic        wide;
  logic        is_bitmap;
  logic [15:0] v16;
  logic        over16;
  logic        over8;
  logic        max_low;
  logic        max_zero;
  logic        div_need;
  logic [31:0] n16;
  logic [15:0] n8;
  logic [16:0] trial;
  logic        ge;
  logic [16:0] diff;

  logic [31:0]           fs_wide;
  logic [COUNT_BITS-1:0] fs;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  fend;
  logic                  out_free;
  logic                  pixel_last;
  logic [7:0]            emit_byte;

  assign max_v     = cfg.max_value;
  assign is_bitmap = (cfg.image_kind == pnmn_pkg::KIND_BITMAP);
  assign wide      = !is_bitmap && (cfg.image_kind != pnmn_pkg::KIND_PIXMAP) &&
                     (max_v > 16'd255);
  assign v16       = {held_r, byte_r};
  assign over16    = v16 > max_v;
  assign over8     = {8'd0, byte_r} > max_v;
  assign max_low   = max_v < 16'd255;
  assign max_zero  = (max_v == 16'd0);
  assign div_need  = wide ? !over16 : (max_low && !over8 && !max_zero);

  // 65535*v and 255*b as shift minus value
  assign n16 = {v16, 16'd0} - {16'd0, v16};
  assign n8  = {byte_r, 8'd0} - {8'd0, byte_r};

  // one restoring division step
  assign trial = {rem_r, acc_r[15]};
  assign ge    = trial >= {1'b0, max_v};
  assign diff  = trial - {1'b0, max_v};

  // frame counter
  assign fs_wide = {8'd0, cfg.frame_samples};
  assign fs      = fs_wide[COUNT_BITS-1:0];
  assign cnt_inc = cnt_r + {{(COUNT_BITS-1){1'b0}}, 1'b1};
  assign fend    = (fs != '0) ? (cnt_inc >= fs) : (cnt_inc == '0);

  assign out_free   = !ovalid_r || out_ready;
  assign pixel_last = fend || (idx_r == 3'd0);

  always_comb begin
    case (cmd.emit_sel)
      pnmn_pkg::EMIT_FIRST:  emit_byte = cfg.big_endian ? acc_r[15:8] : acc_r[7:0];
      pnmn_pkg::EMIT_SECOND: emit_byte = cfg.big_endian ? acc_r[7:0] : acc_r[15:8];
      pnmn_pkg::EMIT_PIXEL:  emit_byte = byte_r[idx_r] ? 8'd0 : 8'd255;
      default:               emit_byte = acc_r[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      held_r   <= 8'd0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.decide) begin
        if (wide) begin
          if (have_r) begin
            have_r <= 1'b0;
          end else begin
            held_r <= byte_r;
            have_r <= 1'b1;
          end
        end else begin
          have_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        ovalid_r <= 1'b1;
        if (cmd.emit_sel != pnmn_pkg::EMIT_FIRST) begin
          cnt_r <= fend ? '0 : cnt_inc;
        end
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) byte_r <= in_byte;
    if (cmd.decide) begin
      step_r <= 4'd0;
      idx_r  <= 3'd7;
      if (wide) begin
        rem_r      <= n16[31:16];
        acc_r      <= over16 ? 16'hFFFF : n16[15:0];
        clampres_r <= over16;
      end else begin
        rem_r      <= 16'd0;
        clampres_r <= max_low && over8;
        if (max_low && over8) begin
          acc_r <= 16'd255;
        end else if (div_need) begin
          acc_r <= n8;
        end else begin
          acc_r <= {8'd0, byte_r};
        end
      end
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? diff[15:0] : trial[15:0];
      acc_r  <= {acc_r[14:0], ge};
      step_r <= step_r + 4'd1;
    end
    if (cmd.emit) begin
      obyte_r <= emit_byte;
      case (cmd.emit_sel)
        pnmn_pkg::EMIT_FIRST: begin
          olast_r  <= 1'b0;
          ofend_r  <= 1'b0;
          oclamp_r <= clampres_r;
        end
        pnmn_pkg::EMIT_PIXEL: begin
          olast_r  <= pixel_last;
          ofend_r  <= fend;
          oclamp_r <= 1'b0;
          idx_r    <= idx_r - 3'd1;
        end
        default: begin
          olast_r  <= 1'b1;
          ofend_r  <= fend;
          oclamp_r <= clampres_r;
        end
      endcase
    end
  end

  assign sts.is_bitmap  = is_bitmap;
  assign sts.wide       = wide;
  assign sts.have_high  = have_r;
  assign sts.div_need   = div_need;
  assign sts.div_last   = (step_r == 4'd15);
  assign sts.out_free   = out_free;
  assign sts.pixel_last = pixel_last;

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
  assign out_fend  = ofend_r;
  assign out_clamp = oclamp_r;

endmodule

// File: rtl/core/pnm_raster_sample_normalizer.sv
`timescale 1ns / 1ps

// Channel   Dir  Ports                           Contents
// in_       in   in_tvalid/in_tready/in_tdata    tdata[7:0] raw_byte
// out_      out  out_tvalid/out_tready/out_tdata tdata[7:0] out_byte, tlast run_last,
//                out_tlast/out_tuser             tuser[0] frame_end, tuser[1] clamped
// cfg_      in   APB psel/penable/pwrite/paddr   image_kind @0x0, max_value @0x4,
//                pwdata/prdata/pready            output_big_endian @0x8, frame_samples @0xC
//
// One byte is worked at a time. A pass-through sample is accepted, decoded and put out
// with one output load; a scaled sample also steps the shared restoring divider (one
// quotient bit per cycle) before its load. A 16-bit gray high byte is only accepted,
// decoded and held; the low byte takes the divider when in range, then two loads. A
// bitmap byte gives one pixel per load. Output stalls hold the controller in its emit state.
// Reset (synchronous, active low) restores register defaults and clears the held
// byte, frame counter and output valid; there is no clearing pass.

module pnm_raster_sample_normalizer #(
  parameter int COUNT_BITS = pnmn_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] raw_byte
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,
  output logic [1:0]  out_tuser,   // [0] frame_end, [1] clamped
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pnmn_pkg::cfg_t cfg;
  pnmn_pkg::cmd_t cmd;
  pnmn_pkg::sts_t sts;
  logic           out_fend;
  logic           out_clamp;

  pnmn_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer: decode, divider stepping, output loads
  pnmn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // byte capture, held high byte, divider, frame counter, output register
  pnmn_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_fend  (out_fend),
    .out_clamp (out_clamp)
  );

  assign out_tuser = {out_clamp, out_fend};

endmodule

// File: sim/pnm_raster_sample_normalizer_test.sv
`timescale 1ns / 1ps

module pnm_raster_sample_normalizer_test;

  // image_kind 3 has no name in the package; the block treats it as a graymap
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam int          HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int          DRAIN_CYCLES = 40;      // covers the slowest byte with margin
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int          MAX_PRINTS   = 40;

  // One output transaction as the block should present it
  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       frame_end;
    logic       clamped;
  } norm_byte_t;

  // Hand-typed value pinned to every output byte of one input transaction
  typedef struct packed {
    logic       pinned;
    logic [7:0] value;
    logic       clamped;
  } pin_t;

  // Directed stimulus: register values in force, the raw byte, and an
  // optional hand-typed output value for rows where it is obvious
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] maxv;
    logic        big_end;
    logic [23:0] frames;
    logic [7:0]  data;
    logic        pinned;
    logic [7:0]  want;
    logic        want_clamp;
  } stim_row_t;

  localparam int N_ROWS = 25;

  stim_row_t directed_rows [0:N_ROWS-1] = '{
    // register defaults after reset: 8-bit gray passes straight through
    '{pnmn_pkg::KIND_GRAYMAP, 16'd255,   1'b1, 24'd1,      8'h00,  1'b1, 8'h00, 1'b0},
    '{pnmn_pkg::KIND_GRAYMAP, 16'd255,   1'b1, 24'd1,      8'hFF,  1'b1, 8'hFF, 1'b0},
    '{pnmn_pkg::KIND_GRAYMAP, 16'd255,   1'b1, 24'd1,      8'h5A,  1'b1, 8'h5A, 1'b0},
    // max below 255: clamp above max, scale at or below
    '{pnmn_pkg::KIND_GRAYMAP, 16'd100,   1'b1, 24'd3,      8'd101, 1'b1, 8'hFF, 1'b1},
    '{pnmn_pkg::KIND_GRAYMAP, 16'd100,   1'b1, 24'd3,      8'd100, 1'b1, 8'hFF, 1'b0},
    '{pnmn_pkg::KIND_GRAYMAP, 16'd100,   1'b1, 24'd3,      8'd50,  1'b0, 8'h00, 1'b0},
    // max of zero: zero stays zero, anything else clamps
    '{pnmn_pkg::KIND_GRAYMAP, 16'd0,     1'b1, 24'd3,      8'h00,  1'b1, 8'h00, 1'b0},
    '{pnmn_pkg::KIND_GRAYMAP, 16'd0,     1'b1, 24'd3,      8'h01,  1'b1, 8'hFF, 1'b1},
    // bitmap, frame of 5 pixels ends inside each of the first two bytes
    '{pnmn_pkg::KIND_BITMAP,  16'd0,     1'b1, 24'd5,      8'h00,  1'b1, 8'hFF, 1'b0},
    '{pnmn_pkg::KIND_BITMAP,  16'd0,     1'b1, 24'd5,      8'hFF,  1'b1, 8'h00, 1'b0},
    '{pnmn_pkg::KIND_BITMAP,  16'd0,     1'b1, 24'hFFFFFF, 8'hA5,  1'b0, 8'h00, 1'b0},
    // pixmap: wide max passes through, small max clamps
    '{pnmn_pkg::KIND_PIXMAP,  16'd1000,  1'b1, 24'hFFFFFF, 8'hC3,  1'b1, 8'hC3, 1'b0},
    '{pnmn_pkg::KIND_PIXMAP,  16'd200,   1'b1, 24'hFFFFFF, 8'd201, 1'b1, 8'hFF, 1'b1},
    // 16-bit gray, big endian, full-scale max
    '{pnmn_pkg::KIND_GRAYMAP, 16'd65535, 1'b1, 24'd2,      8'hFF,  1'b0, 8'h00, 1'b0},
    '{pnmn_pkg::KIND_GRAYMAP, 16'd65535, 1'b1, 24'd2,      8'hFF,  1'b1, 8'hFF, 1'b0},
    '{pnmn_pkg::KIND_GRAYMAP, 16'd65535, 1'b1, 24'd2,      8'h12,  1'b0, 8'h00, 1'b0},
    '{pnmn_pkg::KIND_GRAYMAP, 16'd65535, 1'b1, 24'd2,      8'h34,  1'b0, 8'h00, 1'b0},
    // little endian, 1001 over max 1000 clamps to full scale
    '{pnmn_pkg::KIND_GRAYMAP, 16'd1000,  1'b0, 24'd2,      8'h03,  1'b0, 8'h00, 1'b0},
    '{pnmn_pkg::KIND_GRAYMAP, 16'd1000,  1'b0, 24'd2,      8'hE9,  1'b1, 8'hFF, 1'b1},
    // reserved kind acts as graymap; zero frame length never ends here
    '{KIND_RESERVED,          16'd300,   1'b0, 24'd0,      8'h00,  1'b0, 8'h00, 1'b0},
    '{KIND_RESERVED,          16'd300,   1'b0, 24'd0,      8'h96,  1'b0, 8'h00, 1'b0},
    '{KIND_RESERVED,          16'd300,   1'b0, 24'd0,      8'h77,  1'b0, 8'h00, 1'b0},
    // leave 16-bit mode with a byte held: it gets dropped
    '{pnmn_pkg::KIND_PIXMAP,  16'd255,   1'b0, 24'd0,      8'h10,  1'b1, 8'h10, 1'b0},
    '{pnmn_pkg::KIND_PIXMAP,  16'd255,   1'b0, 24'd0,      8'h80,  1'b0, 8'h00, 1'b0},
    // frame length dropped below the running count: next sample ends it
    '{pnmn_pkg::KIND_PIXMAP,  16'd255,   1'b0, 24'd1,      8'h01,  1'b0, 8'h00, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;     // [7:0] raw_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;            // [7:0] out_byte
  logic        out_tlast;
  logic [1:0]  out_tuser;            // [0] frame_end, [1] clamped
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'h0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Register shadow, mirrors the block after each write
  logic [1:0]  kind_r;
  logic [15:0] maxval_r;
  logic        big_end_r;
  logic [23:0] frame_len_r;

  // Decoder state shadow
  logic [7:0]  held_hi;
  logic        held_hi_valid;
  logic [23:0] frame_pos;

  norm_byte_t  norm_bytes_q[$];    // expected output transactions, oldest first
  pin_t        pinned_q[$];        // one entry per offered input transaction

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int          hold_left = 0;
  int          mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  pnm_raster_sample_normalizer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    if (mismatch_cnt < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Count one sample against the frame length; true when it closes the frame.
  // A zero length only closes on counter wrap.
  function automatic bit advance_frame();
    logic [23:0] nxt;
    bit          fin;
    nxt = frame_pos + 24'd1;
    fin = (frame_len_r != 24'd0) ? (nxt >= frame_len_r) : (nxt == 24'd0);
    frame_pos = fin ? 24'd0 : nxt;
    return fin;
  endfunction

  task automatic queue_norm_byte(input logic [7:0] value, input bit last, input bit fend,
                                 input bit clamp, input pin_t pin);
    norm_byte_t nb;
    nb.value     = pin.pinned ? pin.value : value;
    nb.run_last  = last;
    nb.frame_end = fend;
    nb.clamped   = pin.pinned ? pin.clamped : clamp;
    norm_bytes_q.push_back(nb);
  endtask

  // Predict the output transactions caused by one accepted raw byte
  task automatic normalize_byte(input logic [7:0] b, input pin_t pin);
    logic [15:0] joined;
    logic [31:0] scaled;
    logic [7:0]  res;
    bit          fend;
    bit          clamp;
    if (kind_r == pnmn_pkg::KIND_BITMAP) begin
      held_hi_valid = 1'b0;
      // MSB first, set bit is black; stop early if the frame closes
      for (int i = 7; i >= 0; i--) begin
        fend = advance_frame();
        queue_norm_byte(b[i] ? 8'h00 : 8'hFF, fend || (i == 0), fend, 1'b0, pin);
        if (fend)
          break;
      end
    end else if (kind_r != pnmn_pkg::KIND_PIXMAP && maxval_r > 16'd255) begin
      // 16-bit gray: first byte is only held
      if (!held_hi_valid) begin
        held_hi       = b;
        held_hi_valid = 1'b1;
      end else begin
        held_hi_valid = 1'b0;
        joined = {held_hi, b};
        if (joined > maxval_r) begin
          scaled = 32'hFFFF;
          clamp  = 1'b1;
        end else begin
          scaled = (32'd65535 * joined) / maxval_r;
          clamp  = 1'b0;
        end
        fend = advance_frame();
        queue_norm_byte(big_end_r ? scaled[15:8] : scaled[7:0], 1'b0, 1'b0, clamp, pin);
        queue_norm_byte(big_end_r ? scaled[7:0] : scaled[15:8], 1'b1, fend, clamp, pin);
      end
    end else begin
      held_hi_valid = 1'b0;
      res   = b;
      clamp = 1'b0;
      if (maxval_r < 16'd255) begin
        if (b > maxval_r) begin
          res   = 8'hFF;
          clamp = 1'b1;
        end else if (maxval_r == 16'd0) begin
          res = 8'h00;
        end else begin
          res = 8'((32'd255 * b) / maxval_r);
        end
      end
      fend = advance_frame();
      queue_norm_byte(res, 1'b1, fend, clamp, pin);
    end
  endtask

  // Input monitor: every accepted raw byte runs through the predictor
  always @(posedge clk) begin : accept_mon
    pin_t pin;
    if (rst_n && in_tvalid && in_tready) begin
      pin = pinned_q.pop_front();
      normalize_byte(in_tdata, pin);
    end
  end

  // Output monitor: field-by-field compare against the oldest expectation
  always @(posedge clk) begin : result_mon
    norm_byte_t exp_nb;
    if (rst_n && out_tvalid && out_tready) begin
      if (norm_bytes_q.size() == 0) begin
        report($sformatf("unexpected output byte %02h", out_tdata));
      end else begin
        exp_nb = norm_bytes_q.pop_front();
        if (out_tdata !== exp_nb.value)
          report($sformatf("out_byte %02h, want %02h", out_tdata, exp_nb.value));
        if (out_tlast !== exp_nb.run_last)
          report($sformatf("run_last %b, want %b", out_tlast, exp_nb.run_last));
        if (out_tuser[0] !== exp_nb.frame_end)
          report($sformatf("frame_end %b, want %b", out_tuser[0], exp_nb.frame_end));
        if (out_tuser[1] !== exp_nb.clamped)
          report($sformatf("clamped %b, want %b", out_tuser[1], exp_nb.clamped));
      end
    end
  end

  // Receiver: random backpressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one raw byte, with random gaps, and wait for the transaction
  task automatic send_byte(input logic [7:0] b, input pin_t pin);
    pinned_q.push_back(pin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // Setup then access phase; the register updates on the access edge
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      pnmn_pkg::REG_IMAGE_KIND:    kind_r      = val[1:0];
      pnmn_pkg::REG_MAX_VALUE:     maxval_r    = val[15:0];
      pnmn_pkg::REG_BIG_ENDIAN:    big_end_r   = val[0];
      pnmn_pkg::REG_FRAME_SAMPLES: frame_len_r = val[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering, let every expected byte drain, then give a byte that
  // yields nothing (a held high byte) time to settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (norm_bytes_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    stim_row_t   row;
    pin_t        pin;
    logic [1:0]  new_kind;
    logic [15:0] new_max;
    logic [23:0] new_frames;
    logic [15:0] v;
    logic [7:0]  b;
    bit          wide;

    kind_r        = pnmn_pkg::KIND_GRAYMAP;
    maxval_r      = 16'd255;
    big_end_r     = 1'b1;
    frame_len_r   = 24'd1;
    held_hi       = 8'h00;
    held_hi_valid = 1'b0;
    frame_pos     = 24'd0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, mild idling on both sides
    send_idle_pct = 15;
    recv_idle_pct = 53;
    for (int r = 0; r < N_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind != kind_r || row.maxv != maxval_r || row.big_end != big_end_r ||
          row.frames != frame_len_r) begin
        wait_idle();
        if (row.kind != kind_r)
          reg_write(pnmn_pkg::REG_IMAGE_KIND, 32'(row.kind));
        if (row.maxv != maxval_r)
          reg_write(pnmn_pkg::REG_MAX_VALUE, 32'(row.maxv));
        if (row.big_end != big_end_r)
          reg_write(pnmn_pkg::REG_BIG_ENDIAN, 32'(row.big_end));
        if (row.frames != frame_len_r)
          reg_write(pnmn_pkg::REG_FRAME_SAMPLES, 32'(row.frames));
      end
      pin.pinned  = row.pinned;
      pin.value   = row.want;
      pin.clamped = row.want_clamp;
      send_byte(row.data, pin);
    end

    // Random part: three idling regimes, three register settings each
    for (int ph = 0; ph < 3; ph++) begin
      for (int sub = 0; sub < 3; sub++) begin
        wait_idle();
        send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 53 : 0;
        recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 15 : 0;

        new_kind = 2'($urandom_range(3));
        case ($urandom_range(7))
          0:       new_max = 16'd255;
          1:       new_max = 16'd0;
          2:       new_max = 16'($urandom_range(254, 1));
          3:       new_max = 16'($urandom_range(65535, 256));
          4:       new_max = 16'd65535;
          5:       new_max = 16'($urandom_range(65535));
          6:       new_max = 16'd1;
          default: new_max = 16'($urandom_range(1023, 256));
        endcase
        case ($urandom_range(5))
          4:       new_frames = 24'($urandom());
          5:       new_frames = 24'hFFFFFF;
          default: new_frames = 24'($urandom_range(12, 1));
        endcase
        reg_write(pnmn_pkg::REG_IMAGE_KIND, 32'(new_kind));
        reg_write(pnmn_pkg::REG_MAX_VALUE, 32'(new_max));
        reg_write(pnmn_pkg::REG_BIG_ENDIAN, 32'($urandom_range(1)));
        reg_write(pnmn_pkg::REG_FRAME_SAMPLES, 32'(new_frames));

        // Back up the output once while the sender keeps pushing
        if (ph == 2 && sub == 0)
          hold_req <= ~hold_req;

        wide = (kind_r != pnmn_pkg::KIND_BITMAP && kind_r != pnmn_pkg::KIND_PIXMAP &&
                maxval_r > 16'd255);
        if (wide) begin
          // mostly whole byte pairs, half of them in range so they scale
          for (int k = 0; k < 4; k++) begin
            v = $urandom_range(1) ? 16'($urandom_range(maxval_r))
                                  : 16'($urandom_range(65535));
            send_byte(v[15:8], '0);
            send_byte(v[7:0], '0);
          end
          if ($urandom_range(3) == 0)
            send_byte(8'($urandom_range(255)), '0);
        end else begin
          for (int k = 0; k < 8; k++) begin
            if (maxval_r < 16'd255 && $urandom_range(1))
              b = 8'($urandom_range(maxval_r));
            else
              b = 8'($urandom_range(255));
            send_byte(b, '0);
          end
        end
      end
    end

    wait_idle();
    if (mismatch_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
